>>> hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 stream cipher block.
// ----------------------------------------------------------------------------
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;

  localparam int CC_DOUBLE_ROUNDS = 10;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // configuration register indexes (byte address = 8 * index)
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5,
    REG_CTR    = 3'd6
  } reg_idx_t;

endpackage

>>> hdl/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 encryption / decryption of a message streamed as 8-byte words.
// ----------------------------------------------------------------------------
// Usage:
//   Program key, nonce and initial block counter over the cfg_ APB port
//   (register i at byte address 8*i, 64-bit data) while no word is in flight.
//   Feed message words on in_ (valid/ready); results leave on out_ in order,
//   one per input word. in_last_chunk closes a message and the next word
//   starts again at keystream block zero.
// Block and word flow:
//   The first word of each 64-byte block starts the block function: the
//   round loop in the four-lane core, then the final add; its result is
//   then written to the output register once it is free. No other word is
//   taken meanwhile. The seven other words of the block leave in the cycle
//   after acceptance, one word per cycle while the receiver takes results.
// Reset and stall:
//   rst_n (synchronous, active low) clears the configuration registers, state,
//   output valid, block index and position. A held result waits in the output register; while it waits
//   the first word of a new block is still taken, other words wait.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = CC_DOUBLE_ROUNDS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_chunk,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_chunk,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_chunk,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {S_IDLE, S_BLOCK, S_XOR} state_t;

  state_t      state_r, state_nxt;
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce0_r;
  logic [31:0] nonce1_r, ctr_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] bidx_r, bidx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r;
  logic [3:0]  out_cnt_r;
  logic        out_last_r;
  logic [63:0] it_data_r;
  logic [3:0]  it_cnt_r;
  logic        it_last_r;
  logic [63:0] ks_mem [8];

  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        out_free;
  logic        accept;
  logic        core_start;
  logic        ks_valid;
  blk_t        ks_blk;
  blk_t        init_blk;
  logic        emit;
  logic [63:0] e_data;
  logic [63:0] e_ks;
  logic [3:0]  e_cnt;
  logic        e_last;

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    for (int k = 0; k < 8; k++) begin
      m[8*k +: 8] = {8{n > 4'(k)}};
    end
    return m;
  endfunction

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      REG_KEY0:   cfg_prdata = key0_r;
      REG_KEY1:   cfg_prdata = key1_r;
      REG_KEY2:   cfg_prdata = key2_r;
      REG_KEY3:   cfg_prdata = key3_r;
      REG_NONCE0: cfg_prdata = nonce0_r;
      REG_NONCE1: cfg_prdata = {32'd0, nonce1_r};
      REG_CTR:    cfg_prdata = {32'd0, ctr_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- block function ----------------
  always_comb begin
    init_blk[0]  = SIGMA0;
    init_blk[1]  = SIGMA1;
    init_blk[2]  = SIGMA2;
    init_blk[3]  = SIGMA3;
    init_blk[4]  = key0_r[31:0];
    init_blk[5]  = key0_r[63:32];
    init_blk[6]  = key1_r[31:0];
    init_blk[7]  = key1_r[63:32];
    init_blk[8]  = key2_r[31:0];
    init_blk[9]  = key2_r[63:32];
    init_blk[10] = key3_r[31:0];
    init_blk[11] = key3_r[63:32];
    init_blk[12] = ctr_r + bidx_r;
    init_blk[13] = nonce0_r[31:0];
    init_blk[14] = nonce0_r[63:32];
    init_blk[15] = nonce1_r;
  end

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (core_start),
    .init_i     (init_blk),
    .ks_valid_o (ks_valid),
    .ks_o       (ks_blk)
  );

  // ---------------- word flow ----------------
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && ((pos_r == 3'd0) || out_free);
  assign accept     = in_valid && in_ready;
  assign core_start = accept && (pos_r == 3'd0);

  always_comb begin
    state_nxt     = state_r;
    emit          = 1'b0;
    e_data        = it_data_r;
    e_cnt         = it_cnt_r;
    e_last        = it_last_r;
    e_ks          = ks_mem[pos_r];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (pos_r == 3'd0) begin
            state_nxt = S_BLOCK;
          end else begin
            // mid-block word: keystream already buffered
            emit   = 1'b1;
            e_data = in_data_chunk;
            e_cnt  = in_valid_bytes;
            e_last = in_last_chunk;
          end
        end
      end
      S_BLOCK: begin
        if (ks_valid) begin
          e_ks = {ks_blk[1], ks_blk[0]};
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_XOR;
          end
        end
      end
      S_XOR: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (e_last) begin
        pos_nxt  = '0;
        bidx_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == 3'd7) begin
          bidx_nxt = bidx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      nonce0_r    <= '0;
      nonce1_r    <= '0;
      ctr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_KEY0:   key0_r   <= cfg_pwdata;
          REG_KEY1:   key1_r   <= cfg_pwdata;
          REG_KEY2:   key2_r   <= cfg_pwdata;
          REG_KEY3:   key3_r   <= cfg_pwdata;
          REG_NONCE0: nonce0_r <= cfg_pwdata;
          REG_NONCE1: nonce1_r <= cfg_pwdata[31:0];
          REG_CTR:    ctr_r    <= cfg_pwdata[31:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (core_start) begin
      it_data_r <= in_data_chunk;
      it_cnt_r  <= in_valid_bytes;
      it_last_r <= in_last_chunk;
    end
    if (ks_valid) begin
      for (int k = 0; k < 8; k++) begin
        ks_mem[k] <= {ks_blk[2*k + 1], ks_blk[2*k]};
      end
    end
    if (emit) begin
      out_data_r <= (e_data ^ e_ks) & byte_mask(e_cnt);
      out_cnt_r  <= e_cnt;
      out_last_r <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_chunk = out_data_r;
  assign out_valid_bytes  = out_cnt_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_ks_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    ks_valid |-> (state_r == S_BLOCK))
    else $error("keystream block finished outside of block wait");

  a_mid_block_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (pos_r != 3'd0)) |=> out_valid_r)
    else $error("mid-block word did not reach the output register");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_last) |=> ((pos_r == 3'd0) && (bidx_r == 32'd0)))
    else $error("last word did not restart the block index");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept)
    else $error("word accepted while a block is in progress");
`endif

endmodule

>>> hdl/cc20_qr.sv
// ----------------------------------------------------------------------------
// cc20_qr
// One ChaCha quarter-round lane: four add / xor / rotate steps.
// ----------------------------------------------------------------------------
module cc20_qr
  import cc20_pkg::*;
(
  input  word_t a_i,
  input  word_t b_i,
  input  word_t c_i,
  input  word_t d_i,
  output word_t a_o,
  output word_t b_o,
  output word_t c_o,
  output word_t d_o
);

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  word_t a1, b1, c1, d1;

  always_comb begin
    a1  = a_i + b_i;
    d1  = rotl(d_i ^ a1, 16);
    c1  = c_i + d1;
    b1  = rotl(b_i ^ c1, 12);
    a_o = a1 + b1;
    d_o = rotl(d1 ^ a_o, 8);
    c_o = c1 + d_o;
    b_o = rotl(b1 ^ c_o, 7);
  end

endmodule

>>> hdl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Block function: four quarter-round lanes run one column or diagonal round
// per cycle on the working state, then a final add merges it with the input.
// ----------------------------------------------------------------------------
module cc20_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = CC_DOUBLE_ROUNDS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start_i,
  input  blk_t init_i,
  output logic ks_valid_o,
  output blk_t ks_o
);

  localparam int NumRounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW      = $clog2(NumRounds);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  cstate_t          state_r, state_nxt;
  logic [RndW-1:0]  rnd_r, rnd_nxt;
  blk_t             x_r, x_nxt;
  blk_t             init_r, init_nxt;
  word_t            la [4];
  word_t            lb [4];
  word_t            lc [4];
  word_t            ld [4];
  word_t            qa [4];
  word_t            qb [4];
  word_t            qc [4];
  word_t            qd [4];
  logic             diag;

  assign diag = rnd_r[0];

  // lane j takes a column (j, 4+j, 8+j, 12+j) or a diagonal of the state
  for (genvar j = 0; j < 4; j++) begin : g_lane
    assign la[j] = x_r[j];
    assign lb[j] = diag ? x_r[4 + ((j + 1) & 3)]  : x_r[4 + j];
    assign lc[j] = diag ? x_r[8 + ((j + 2) & 3)]  : x_r[8 + j];
    assign ld[j] = diag ? x_r[12 + ((j + 3) & 3)] : x_r[12 + j];

    cc20_qr u_qr (
      .a_i (la[j]),
      .b_i (lb[j]),
      .c_i (lc[j]),
      .d_i (ld[j]),
      .a_o (qa[j]),
      .b_o (qb[j]),
      .c_o (qc[j]),
      .d_o (qd[j])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    x_nxt      = x_r;
    init_nxt   = init_r;
    ks_valid_o = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (start_i) begin
          x_nxt     = init_i;
          init_nxt  = init_i;
          rnd_nxt   = '0;
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        for (int j = 0; j < 4; j++) begin
          x_nxt[j] = qa[j];
          if (diag) begin
            x_nxt[4 + ((j + 1) & 3)]  = qb[j];
            x_nxt[8 + ((j + 2) & 3)]  = qc[j];
            x_nxt[12 + ((j + 3) & 3)] = qd[j];
          end else begin
            x_nxt[4 + j]  = qb[j];
            x_nxt[8 + j]  = qc[j];
            x_nxt[12 + j] = qd[j];
          end
        end
        if (rnd_r == RndW'(NumRounds - 1)) begin
          state_nxt = C_FINAL;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      C_FINAL: begin
        ks_valid_o = 1'b1;
        state_nxt  = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // merge: keystream word = working word + input word
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_o[i] = x_r[i] + init_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    init_r <= init_nxt;
  end

endmodule

>>> sim/chacha20_stream_cipher_test.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_test
// Self-checking bench for the ChaCha20 stream cipher block. A directed table
// covers reset state, byte-count extremes and counter wrap. Random messages
// follow under changing key, nonce and counter settings, with bursty input
// and a stalling receiver. Every result word is checked against a block-level
// cipher model kept inside the bench.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_test;
  import cc20_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * CC_DOUBLE_ROUNDS + 10;
  localparam int RANDOM_WORDS = 450;
  localparam int MAX_REPORTS = 10;
  localparam logic [5:0] UNMAPPED_ADDR = 6'd56;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [63:0] cipher;
    logic [3:0]  nbytes;
    logic        last;
  } cipher_word_t;

  typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [5:0]  addr;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        known;
    logic [63:0] cipher;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_chunk = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last_chunk = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_cipher_chunk;
  logic [3:0]  out_valid_bytes;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // typed-in cipher value riding along with the current input word
  logic        in_known = 1'b0;
  logic [63:0] in_known_cipher = '0;

  chacha20_stream_cipher dut (.*);

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // cipher model: register copies and keystream position
  // --------------------------------------------------------------------------
  logic [63:0] key_q [4] = '{default: '0};
  logic [63:0] nonce_lo_q = '0;
  word_t       nonce_hi_q = '0;
  word_t       ctr_init_q = '0;
  word_t       blk_index_q = '0;
  word_t       ks_q [16];
  logic [2:0]  chunk_pos_q = '0;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(inout word_t a, inout word_t b,
                                        inout word_t c, inout word_t d);
    a += b; d ^= a; d = rotl(d, 16);
    c += d; b ^= c; b = rotl(b, 12);
    a += b; d ^= a; d = rotl(d, 8);
    c += d; b ^= c; b = rotl(b, 7);
  endfunction

  function automatic void refill_keystream();
    word_t seed [16];
    word_t x [16];
    seed[0] = SIGMA0;
    seed[1] = SIGMA1;
    seed[2] = SIGMA2;
    seed[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      seed[4 + 2 * k] = key_q[k][31:0];
      seed[5 + 2 * k] = key_q[k][63:32];
    end
    seed[12] = ctr_init_q + blk_index_q;
    seed[13] = nonce_lo_q[31:0];
    seed[14] = nonce_lo_q[63:32];
    seed[15] = nonce_hi_q;
    x = seed;
    for (int r = 0; r < CC_DOUBLE_ROUNDS; r++) begin
      quarter_round(x[0], x[4], x[8],  x[12]);
      quarter_round(x[1], x[5], x[9],  x[13]);
      quarter_round(x[2], x[6], x[10], x[14]);
      quarter_round(x[3], x[7], x[11], x[15]);
      quarter_round(x[0], x[5], x[10], x[15]);
      quarter_round(x[1], x[6], x[11], x[12]);
      quarter_round(x[2], x[7], x[8],  x[13]);
      quarter_round(x[3], x[4], x[9],  x[14]);
    end
    for (int k = 0; k < 16; k++) ks_q[k] = x[k] + seed[k];
  endfunction

  function automatic cipher_word_t encrypt_word(logic [63:0] data, logic [3:0] nbytes,
                                                logic last);
    cipher_word_t res;
    logic [63:0]  ks;
    logic [63:0]  mask;
    if (chunk_pos_q == 3'd0) refill_keystream();
    ks = {ks_q[2 * chunk_pos_q + 1], ks_q[2 * chunk_pos_q]};
    mask = (nbytes >= 4'd8) ? ALL_ONES : (64'd1 << (8 * nbytes)) - 64'd1;
    res.cipher = (data ^ ks) & mask;
    res.nbytes = nbytes;
    res.last = last;
    if (last) begin
      blk_index_q = '0;
      chunk_pos_q = '0;
    end else begin
      chunk_pos_q = chunk_pos_q + 3'd1;
      if (chunk_pos_q == 3'd0) blk_index_q = blk_index_q + 32'd1;
    end
    return res;
  endfunction

  function automatic void apply_write(logic [5:0] addr, logic [63:0] value);
    case (addr[5:3])
      REG_KEY0:   key_q[0] = value;
      REG_KEY1:   key_q[1] = value;
      REG_KEY2:   key_q[2] = value;
      REG_KEY3:   key_q[3] = value;
      REG_NONCE0: nonce_lo_q = value;
      REG_NONCE1: nonce_hi_q = value[31:0];
      REG_CTR:    ctr_init_q = value[31:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  cipher_word_t due_q [$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin : track
    cipher_word_t calc;
    cipher_word_t got;
    cipher_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        calc = encrypt_word(in_data_chunk, in_valid_bytes, in_last_chunk);
        if (in_known) calc.cipher = in_known_cipher;
        due_q.push_back(calc);
      end
      if (out_valid && out_ready) begin
        got = '{out_cipher_chunk, out_valid_bytes, out_last};
        words_out <= words_out + 1;
        if (due_q.size() == 0) begin
          note_mismatch($sformatf("word %0d unexpected: cipher=%h bytes=%0d last=%0b",
                                  words_out, got.cipher, got.nbytes, got.last));
        end else begin
          want = due_q.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "word %0d: expected cipher=%h bytes=%0d last=%0b, got cipher=%h bytes=%0d last=%0b",
              words_out, want.cipher, want.nbytes, want.last,
              got.cipher, got.nbytes, got.last));
        end
      end
    end
  end

  // receiver: alternate ready runs, some long, with short stalls
  int rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        rx_left = $urandom_range(5, 1);
      end else begin
        out_ready <= 1'b1;
        rx_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 30) : $urandom_range(8, 1);
      end
    end else begin
      rx_left--;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("chacha20_stream_cipher regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int random_sent = 0;
  bit no_idle = 1'b0;

  task automatic send_word(logic [63:0] data, logic [3:0] nbytes, logic last,
                           logic known, logic [63:0] cipher);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = no_idle ? 0 : (($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_chunk <= data;
    in_valid_bytes <= nbytes;
    in_last_chunk <= last;
    in_known <= known;
    in_known_cipher <= cipher;
    do @(posedge clk); while (!in_ready);
    words_in++;
  endtask

  // hold input until every outstanding word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_out < words_in) @(posedge clk);
  endtask

  task automatic write_reg(logic [5:0] addr, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    apply_write(addr, value);
    @(posedge clk);
  endtask

  task automatic random_setting();
    logic [63:0] value;
    for (int i = REG_KEY0; i <= REG_CTR; i++) begin
      if ($urandom_range(1, 0) == 1) begin
        case ($urandom_range(4, 0))
          0: value = '0;
          1: value = ALL_ONES;
          // counter a few blocks short of wrapping
          2: value = {32'hFFFF_FFFF, 32'hFFFF_FFFF - $urandom_range(3, 0)};
          default: value = {$urandom, $urandom};
        endcase
        write_reg({reg_idx_t'(i), 3'b000}, value);
      end
    end
    if ($urandom_range(3, 0) == 0) write_reg(UNMAPPED_ADDR, {$urandom, $urandom});
  endtask

  task automatic random_message(bit open);
    int len;
    len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    for (int k = 1; k <= len; k++) begin
      logic [3:0] nb;
      logic fin;
      fin = (k == len) && !open;
      if (fin)
        nb = ($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 0))
                                         : 4'($urandom_range(8, 1));
      else
        nb = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0)) : 4'd8;
      send_word({$urandom, $urandom}, nb, fin, 1'b0, '0);
      random_sent++;
    end
  endtask

  function automatic stim_row_t row_word(logic [63:0] data, logic [3:0] nbytes, logic last);
    return '{ROW_WORD, '0, data, nbytes, last, 1'b0, '0};
  endfunction

  function automatic stim_row_t row_known(logic [63:0] data, logic [3:0] nbytes, logic last,
                                          logic [63:0] cipher);
    return '{ROW_WORD, '0, data, nbytes, last, 1'b1, cipher};
  endfunction

  function automatic stim_row_t row_write(logic [5:0] addr, logic [63:0] value);
    return '{ROW_WRITE, addr, value, '0, 1'b0, 1'b0, '0};
  endfunction

  stim_row_t stim_tbl [$];

  initial begin
    stim_tbl = '{
      // zero key, nonce and counter: block 0 is the well-known all-zero keystream
      row_known(64'h0, 4'd8, 1'b0, 64'h903d_f1a0_ade0_b876),
      row_known(64'h0, 4'd8, 1'b0, 64'h28bd_8653_e56a_5d40),
      row_word(ALL_ONES, 4'd8, 1'b0),
      row_known(ALL_ONES, 4'd0, 1'b0, 64'h0),      // empty word still uses its slot
      row_word(ALL_ONES, 4'd15, 1'b0),             // count above eight masks as eight
      row_word(ALL_ONES, 4'd3, 1'b0),              // short word inside a message
      row_word(64'h5555_5555_5555_5555, 4'd9, 1'b0),
      row_word(64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0),
      row_word(64'h0123_4567_89ab_cdef, 4'd8, 1'b0),
      row_word(64'hfedc_ba98_7654_3210, 4'd1, 1'b1),
      row_word(64'h8000_0000_0000_0001, 4'd8, 1'b1),
      row_known(ALL_ONES, 4'd0, 1'b1, 64'h0),
      row_write({REG_KEY0, 3'b000}, ALL_ONES),
      row_write({REG_KEY1, 3'b000}, 64'h0f1e_2d3c_4b5a_6978),
      row_write({REG_KEY2, 3'b000}, 64'h8796_a5b4_c3d2_e1f0),
      row_write({REG_KEY3, 3'b000}, ALL_ONES),
      row_write({REG_NONCE0, 3'b000}, ALL_ONES),
      row_write({REG_NONCE1, 3'b000}, ALL_ONES),
      row_write({REG_CTR, 3'b000}, 64'hFFFF_FFFF),
      row_write(UNMAPPED_ADDR, 64'hdead_beef_dead_beef),
      // counter wraps to zero between the eighth and ninth word
      row_word(64'h0, 4'd8, 1'b0),
      row_word(ALL_ONES, 4'd8, 1'b0),
      row_word(64'h1122_3344_5566_7788, 4'd8, 1'b0),
      row_word(64'h8877_6655_4433_2211, 4'd8, 1'b0),
      row_word(64'hf0f0_f0f0_0f0f_0f0f, 4'd8, 1'b0),
      row_word(64'h0000_ffff_0000_ffff, 4'd8, 1'b0),
      row_word(64'h7fff_ffff_ffff_fffe, 4'd8, 1'b0),
      row_word(64'h0000_0000_0000_0080, 4'd8, 1'b0),
      row_word(64'hc3c3_3c3c_a5a5_5a5a, 4'd5, 1'b1)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(stim_tbl[i].addr, stim_tbl[i].data);
      end else begin
        send_word(stim_tbl[i].data, stim_tbl[i].nbytes, stim_tbl[i].last,
                  stim_tbl[i].known, stim_tbl[i].cipher);
      end
    end

    // each phase: drain, reprogram, then a few messages; the last one may stay
    // open so the next setting lands mid-message
    while (random_sent < RANDOM_WORDS) begin
      int n_msgs;
      wait_drained();
      random_setting();
      no_idle = ($urandom_range(4, 0) == 0);
      n_msgs = $urandom_range(3, 1);
      for (int m = 1; m <= n_msgs; m++)
        random_message((m == n_msgs) && ($urandom_range(5, 0) == 0));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_q.size() != 0)
      note_mismatch($sformatf("%0d expected words never arrived", due_q.size()));

    if (errors == 0) begin
      $display("chacha20_stream_cipher regression: pass");
    end else begin
      $display("chacha20_stream_cipher regression: fail");
    end
    $finish;
  end

endmodule
